[sv/vtesc_pkg.sv]
// vtesc_pkg: shared types and constants for the terminal escape key decoder
// character codes, action codes and state encodings; no dependencies
package vtesc_pkg;

    // default depth of the kept control sequence text
    localparam int MAX_KEPT_DEFAULT = 15;

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_HT     = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_FIN_LO = 8'h40;
    localparam logic [7:0] CH_UP     = 8'h41;
    localparam logic [7:0] CH_DOWN   = 8'h42;
    localparam logic [7:0] CH_RIGHT  = 8'h43;
    localparam logic [7:0] CH_LEFT   = 8'h44;
    localparam logic [7:0] CH_END    = 8'h46;
    localparam logic [7:0] CH_HOME   = 8'h48;
    localparam logic [7:0] CH_SS3    = 8'h4F;
    localparam logic [7:0] CH_CSI    = 8'h5B;
    localparam logic [7:0] CH_WLEFT  = 8'h62;
    localparam logic [7:0] CH_WRIGHT = 8'h66;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_FIN_HI = 8'h7E;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    // tilde sequence parameter values
    localparam logic [7:0] NUM_HOME1  = 8'd1;
    localparam logic [7:0] NUM_DELETE = 8'd3;
    localparam logic [7:0] NUM_END1   = 8'd4;
    localparam logic [7:0] NUM_HOME2  = 8'd7;
    localparam logic [7:0] NUM_END2   = 8'd8;
    localparam logic [7:0] NUM_PASTE  = 8'd200;
    localparam logic [7:0] NUM_MAX    = 8'd255;

    typedef enum logic [3:0] {
        ACT_NONE        = 4'd0,
        ACT_UP          = 4'd1,
        ACT_DOWN        = 4'd2,
        ACT_LEFT        = 4'd3,
        ACT_RIGHT       = 4'd4,
        ACT_HOME        = 4'd5,
        ACT_END         = 4'd6,
        ACT_DELETE      = 4'd7,
        ACT_WORD_LEFT   = 4'd8,
        ACT_WORD_RIGHT  = 4'd9,
        ACT_WORD_DELETE = 4'd10,
        ACT_PASTE       = 4'd11
    } t_action;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_ESC  = 3'b010,
        PH_SEQ  = 3'b100
    } t_phase;

    typedef enum logic [2:0] {
        NUM_BLANKS = 3'b001,
        NUM_DIGITS = 3'b010,
        NUM_DONE   = 3'b100
    } t_num_phase;

endpackage

[sv/vt_escape_key_decoder.sv]
// vt_escape_key_decoder: terminal byte stream to editing key actions
// depends on vtesc_pkg for character codes, action codes and state types
//
// usage
//   slave side takes one terminal byte per request: s_axis_tdata[7:0] is the
//   byte, s_axis_tlast marks end of input (byte ignored then). end of input
//   inside an escape sequence yields one result with action none.
//   master side carries at most one result per request: tdata holds the key
//   action and the plain byte, tuser flags a byte passed through unchanged.
//   plain bytes, escape prefixes and control sequence parameters are decoded
//   by a small state machine; the sequence text is never stored, only the
//   parameter number with sign and overflow flags, a semicolon flag, a nul flag and a kept-byte count.
// timing
//   result appears in the cycle after the request is accepted, from the output
//   register. throughput is one request per cycle while the output register
//   is empty or being drained: the state update and action decode are
//   combinational between the state registers and the output register.
// reset and stall
//   synchronous active low reset returns to idle and empties the output
//   register. while the receiver stalls, a new request is still taken only if
//   the output register is empty;
//   otherwise s_axis_tready drops and the pending result holds.
module vt_escape_key_decoder
    import vtesc_pkg::*;
#(
    parameter int MAX_KEPT = MAX_KEPT_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [3:0] key_action, [11:4] plain_byte, rest zero
    output logic        m_axis_tuser    // is_plain
);

    localparam int KW = $clog2(MAX_KEPT + 1);

    // sequence state
    t_phase      r_phase, n_phase;
    logic [KW-1:0] r_kept, n_kept;
    logic        r_text_ended, n_text_ended;
    logic        r_semi, n_semi;
    t_num_phase  r_nphase, n_nphase;
    logic        r_neg, n_neg;
    logic [7:0]  r_val, n_val;
    logic        r_ovf, n_ovf;

    // output register
    logic        r_out_valid;
    t_action     r_out_action;
    logic        r_out_plain;
    logic [7:0]  r_out_byte;

    // per-request decode
    logic        w_accept;
    logic [7:0]  w_b;
    logic        w_emit;
    t_action     w_action;
    t_action     w_final_action;
    logic        w_plain;
    logic [7:0]  w_plain_byte;
    logic        w_is_final;
    logic        w_blank;
    logic        w_sign;
    logic        w_digit;
    logic [11:0] w_prod;
    logic        w_clear;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_b           = s_axis_tdata;

    assign w_is_final = (w_b >= CH_FIN_LO) && (w_b <= CH_FIN_HI);
    assign w_blank    = (w_b == CH_SPACE) || ((w_b >= CH_HT) && (w_b <= CH_CR));
    assign w_sign     = (w_b == CH_PLUS) || (w_b == CH_MINUS);
    assign w_digit    = (w_b >= CH_ZERO) && (w_b <= CH_NINE);
    // value * 10 + digit, wide enough to see overflow
    assign w_prod     = ({4'd0, r_val} << 3) + ({4'd0, r_val} << 1)
                      + {4'd0, w_b - CH_ZERO};

    // action picked by the final byte of a control sequence
    always_comb begin
        case (w_b)
            CH_UP:    w_final_action = ACT_UP;
            CH_DOWN:  w_final_action = ACT_DOWN;
            CH_RIGHT: w_final_action = r_semi ? ACT_WORD_RIGHT : ACT_RIGHT;
            CH_LEFT:  w_final_action = r_semi ? ACT_WORD_LEFT : ACT_LEFT;
            CH_HOME:  w_final_action = ACT_HOME;
            CH_END:   w_final_action = ACT_END;
            CH_TILDE: begin
                if (r_neg || r_ovf) begin
                    w_final_action = ACT_NONE;
                end else begin
                    case (r_val)
                        NUM_HOME1, NUM_HOME2: w_final_action = ACT_HOME;
                        NUM_END1, NUM_END2:   w_final_action = ACT_END;
                        NUM_DELETE:           w_final_action = ACT_DELETE;
                        NUM_PASTE:            w_final_action = ACT_PASTE;
                        default:              w_final_action = ACT_NONE;
                    endcase
                end
            end
            default:  w_final_action = ACT_NONE;
        endcase
    end

    // next state and result for the current request
    always_comb begin
        n_phase      = r_phase;
        n_kept       = r_kept;
        n_text_ended = r_text_ended;
        n_semi       = r_semi;
        n_nphase     = r_nphase;
        n_neg        = r_neg;
        n_val        = r_val;
        n_ovf        = r_ovf;
        w_emit       = 1'b0;
        w_action     = ACT_NONE;
        w_plain      = 1'b0;
        w_plain_byte = 8'd0;
        w_clear      = 1'b0;

        if (s_axis_tlast) begin
            // end of input aborts a pending sequence
            if (r_phase != PH_IDLE) begin
                n_phase = PH_IDLE;
                w_clear = 1'b1;
                w_emit  = 1'b1;
            end
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (w_b == CH_ESC) begin
                        n_phase = PH_ESC;
                    end else begin
                        w_emit       = 1'b1;
                        w_plain      = 1'b1;
                        w_plain_byte = w_b;
                    end
                end
                PH_ESC: begin
                    if ((w_b == CH_CSI) || (w_b == CH_SS3)) begin
                        n_phase = PH_SEQ;
                        w_clear = 1'b1;
                    end else begin
                        n_phase = PH_IDLE;
                        w_emit  = 1'b1;
                        case (w_b)
                            CH_WLEFT:      w_action = ACT_WORD_LEFT;
                            CH_WRIGHT:     w_action = ACT_WORD_RIGHT;
                            CH_DEL, CH_BS: w_action = ACT_WORD_DELETE;
                            default:       w_action = ACT_NONE;
                        endcase
                    end
                end
                PH_SEQ: begin
                    if (w_is_final) begin
                        n_phase  = PH_IDLE;
                        w_clear  = 1'b1;
                        w_emit   = 1'b1;
                        w_action = w_final_action;
                    end else if (r_kept < KW'(MAX_KEPT)) begin
                        n_kept = r_kept + KW'(1);
                        if (!r_text_ended) begin
                            if (w_b == CH_NUL) begin
                                n_text_ended = 1'b1;
                            end else begin
                                if (w_b == CH_SEMI) begin
                                    n_semi = 1'b1;
                                end
                                unique case (r_nphase)
                                    NUM_BLANKS: begin
                                        if (w_sign) begin
                                            n_neg    = (w_b == CH_MINUS);
                                            n_nphase = NUM_DIGITS;
                                        end else if (w_digit) begin
                                            n_nphase = NUM_DIGITS;
                                            n_val    = w_prod[7:0];
                                        end else if (!w_blank) begin
                                            n_nphase = NUM_DONE;
                                        end
                                    end
                                    NUM_DIGITS: begin
                                        if (!w_digit) begin
                                            n_nphase = NUM_DONE;
                                        end else if (w_prod > 12'(NUM_MAX)) begin
                                            n_val = NUM_MAX;
                                            n_ovf = 1'b1;
                                        end else begin
                                            n_val = w_prod[7:0];
                                        end
                                    end
                                    NUM_DONE: begin
                                        n_nphase = NUM_DONE;
                                    end
                                    default: begin
                                        n_nphase = NUM_DONE;
                                    end
                                endcase
                            end
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        // sequence bookkeeping starts fresh on entry and on every end
        if (w_clear) begin
            n_kept       = '0;
            n_text_ended = 1'b0;
            n_semi       = 1'b0;
            n_nphase     = NUM_BLANKS;
            n_neg        = 1'b0;
            n_val        = 8'd0;
            n_ovf        = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_kept       <= '0;
            r_text_ended <= 1'b0;
            r_semi       <= 1'b0;
            r_nphase     <= NUM_BLANKS;
            r_neg        <= 1'b0;
            r_val        <= 8'd0;
            r_ovf        <= 1'b0;
        end else if (w_accept) begin
            r_phase      <= n_phase;
            r_kept       <= n_kept;
            r_text_ended <= n_text_ended;
            r_semi       <= n_semi;
            r_nphase     <= n_nphase;
            r_neg        <= n_neg;
            r_val        <= n_val;
            r_ovf        <= n_ovf;
        end
    end

    // output register: refilled on accept, drained by the receiver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= w_emit;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_out_action <= w_action;
            r_out_plain  <= w_plain;
            r_out_byte   <= w_plain_byte;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_byte, r_out_action};
    assign m_axis_tuser  = r_out_plain;

endmodule

[dv/vtesc_key_checker.sv]
// vtesc_key_checker: watches both streams of the escape key decoder, predicts each key result
// depends on vtesc_pkg for character codes, action codes and state encodings
module vtesc_key_checker
    import vtesc_pkg::*;
#(
    parameter int MAX_KEPT = MAX_KEPT_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [7:0]  i_req_data,   // [7:0] in_byte
    input  logic        i_req_last,   // end_of_input
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [15:0] i_rsp_data,   // [3:0] key_action, [11:4] plain_byte, rest zero
    input  logic        i_rsp_user,   // is_plain
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_action    act;
        logic       plain;
        logic [7:0] pbyte;
    } t_key_result;

    t_key_result expected_keys[$];

    // decoder state
    t_phase     seq_phase;
    int         kept_count;
    logic       text_ended;
    logic       semi_seen;
    t_num_phase num_phase;
    logic       num_neg;
    logic [7:0] num_val;
    logic       num_ovf;

    function automatic void clear_sequence();
        kept_count = 0;
        text_ended = 1'b0;
        semi_seen  = 1'b0;
        num_phase  = NUM_BLANKS;
        num_neg    = 1'b0;
        num_val    = 8'd0;
        num_ovf    = 1'b0;
    endfunction

    function automatic void expect_key(input t_action act, input logic plain,
                                       input logic [7:0] pbyte);
        t_key_result k;
        k.act   = act;
        k.plain = plain;
        k.pbyte = pbyte;
        expected_keys.push_back(k);
    endfunction

    // atoi-like parameter parse, value saturates at 255
    function automatic void feed_number(input logic [7:0] b);
        int v;
        if (num_phase == NUM_BLANKS) begin
            if (b == CH_SPACE || (b >= CH_HT && b <= CH_CR))
                return;
            if (b == CH_PLUS || b == CH_MINUS) begin
                num_neg   = (b == CH_MINUS);
                num_phase = NUM_DIGITS;
                return;
            end
            num_phase = NUM_DIGITS;
        end
        if (num_phase != NUM_DIGITS)
            return;
        if (b < CH_ZERO || b > CH_NINE) begin
            num_phase = NUM_DONE;
            return;
        end
        v = int'(num_val) * 10 + int'(b - CH_ZERO);
        if (v > 255) begin
            v       = 255;
            num_ovf = 1'b1;
        end
        num_val = v[7:0];
    endfunction

    function automatic t_action final_action(input logic [7:0] b);
        case (b)
            CH_UP:    return ACT_UP;
            CH_DOWN:  return ACT_DOWN;
            CH_RIGHT: return semi_seen ? ACT_WORD_RIGHT : ACT_RIGHT;
            CH_LEFT:  return semi_seen ? ACT_WORD_LEFT : ACT_LEFT;
            CH_HOME:  return ACT_HOME;
            CH_END:   return ACT_END;
            CH_TILDE: begin
                if (num_neg || num_ovf)
                    return ACT_NONE;
                case (num_val)
                    NUM_HOME1, NUM_HOME2: return ACT_HOME;
                    NUM_END1, NUM_END2:   return ACT_END;
                    NUM_DELETE:           return ACT_DELETE;
                    NUM_PASTE:            return ACT_PASTE;
                    default:              return ACT_NONE;
                endcase
            end
            default:  return ACT_NONE;
        endcase
    endfunction

    function automatic void decode_request(input logic [7:0] b, input logic eoi);
        if (eoi) begin
            if (seq_phase != PH_IDLE) begin
                seq_phase = PH_IDLE;
                clear_sequence();
                expect_key(ACT_NONE, 1'b0, 8'd0);
            end
            return;
        end
        case (seq_phase)
            PH_IDLE: begin
                if (b == CH_ESC)
                    seq_phase = PH_ESC;
                else
                    expect_key(ACT_NONE, 1'b1, b);
            end
            PH_ESC: begin
                if (b == CH_CSI || b == CH_SS3) begin
                    seq_phase = PH_SEQ;
                    clear_sequence();
                end else begin
                    seq_phase = PH_IDLE;
                    if (b == CH_WLEFT)
                        expect_key(ACT_WORD_LEFT, 1'b0, 8'd0);
                    else if (b == CH_WRIGHT)
                        expect_key(ACT_WORD_RIGHT, 1'b0, 8'd0);
                    else if (b == CH_DEL || b == CH_BS)
                        expect_key(ACT_WORD_DELETE, 1'b0, 8'd0);
                    else
                        expect_key(ACT_NONE, 1'b0, 8'd0);
                end
            end
            default: begin
                if (b >= CH_FIN_LO && b <= CH_FIN_HI) begin
                    expect_key(final_action(b), 1'b0, 8'd0);
                    seq_phase = PH_IDLE;
                    clear_sequence();
                end else if (kept_count < MAX_KEPT) begin
                    kept_count++;
                    if (!text_ended) begin
                        if (b == CH_NUL) begin
                            text_ended = 1'b1;
                        end else begin
                            if (b == CH_SEMI)
                                semi_seen = 1'b1;
                            feed_number(b);
                        end
                    end
                end
            end
        endcase
    endfunction

    function automatic void check_key(input logic [15:0] data, input logic user);
        t_key_result k;
        if (expected_keys.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("%0t unexpected key result: action %0d plain %0b byte %02h",
                         $realtime, data[3:0], user, data[11:4]);
            return;
        end
        k = expected_keys.pop_front();
        if (data[3:0] !== k.act || user !== k.plain || data[11:4] !== k.pbyte
                || data[15:12] !== 4'd0) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("%0t key mismatch: expected action %0d plain %0b byte %02h, got %s",
                         $realtime, k.act, k.plain, k.pbyte,
                         $sformatf("action %0d plain %0b byte %02h pad %h",
                                   data[3:0], user, data[11:4], data[15:12]));
        end
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        seq_phase    = PH_IDLE;
        clear_sequence();
    end

    // result at an edge always comes from an earlier request, so check first
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seq_phase = PH_IDLE;
            clear_sequence();
            expected_keys.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready)
                check_key(i_rsp_data, i_rsp_user);
            if (i_req_valid && i_req_ready)
                decode_request(i_req_data, i_req_last);
        end
        o_pending = expected_keys.size();
    end

endmodule

[dv/tb_vt_escape_key_decoder.sv]
// tb_vt_escape_key_decoder: stimulus and verdict for the terminal escape key decoder
// depends on vtesc_pkg, vt_escape_key_decoder and the vtesc_key_checker module
module tb_vt_escape_key_decoder;
    timeunit 1ns;
    timeprecision 1ps;
    import vtesc_pkg::*;

    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_ITEMS = 500;
    localparam int HOLD_CYCLES  = 40;    // long receiver hold-off in the first phase
    localparam int DRAIN_CYCLES = 8;     // settling time after the last result, plenty of margin
    localparam int TIMEOUT_NS   = 2_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] in_byte
    logic        s_axis_tlast;     // end_of_input
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;     // [3:0] key_action, [11:4] plain_byte, rest zero
    logic        m_axis_tuser;     // is_plain

    int fail_count;
    int pending;
    int items_sent;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_req;

    vt_escape_key_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    vtesc_key_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_req_last   (s_axis_tlast),
        .i_rsp_valid  (m_axis_tvalid),
        .i_rsp_ready  (m_axis_tready),
        .i_rsp_data   (m_axis_tdata),
        .i_rsp_user   (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 20 ns clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // hard stop in case a handshake never completes
    initial begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off so the output register
    // fills and the block has to back-pressure its request side
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req <= 1'b0;
                repeat (HOLD_CYCLES) begin
                    m_axis_tready <= 1'b0;
                    @(negedge i_clk);
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // one request; called and returns at a falling edge, valid stays high
    // across back-to-back requests
    task automatic send_request(input logic [7:0] b, input logic eoi);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eoi;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_request(b, 1'b0);
    endtask

    // end of input; the byte lane carries junk that must be ignored
    task automatic send_eoi();
        send_request(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // byte that is never a final byte of a control sequence
    function automatic logic [7:0] param_noise();
        if ($urandom_range(1))
            return 8'($urandom_range(8'h3F));
        return 8'($urandom_range(8'hFF, CH_DEL));
    endfunction

    // decimal parameter, biased toward the values the tilde decode cares about
    task automatic send_number();
        int v;
        case ($urandom_range(11))
            0:       v = NUM_HOME1;
            1:       v = NUM_DELETE;
            2:       v = NUM_END1;
            3:       v = NUM_HOME2;
            4:       v = NUM_END2;
            5, 6:    v = NUM_PASTE;
            7:       v = NUM_MAX;
            8:       v = 256;
            9:       v = 2000;
            default: v = $urandom_range(999);
        endcase
        if ($urandom_range(7) == 0)
            send_byte(CH_ZERO);    // leading zero
        send_text($sformatf("%0d", v));
    endtask

    // parameter text between the introducer and the final byte
    task automatic send_params();
        int n;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
                // well-formed number: blanks, sign, digits, maybe a second field
                n = $urandom_range(3);
                repeat (n)
                    send_byte($urandom_range(1) ? CH_SPACE : 8'($urandom_range(CH_CR, CH_HT)));
                case ($urandom_range(9))
                    0:       send_byte(CH_MINUS);
                    1:       send_byte(CH_PLUS);
                    default: ;
                endcase
                send_number();
                if ($urandom_range(2) == 0) begin
                    send_byte(CH_SEMI);
                    send_number();
                end
            end
            5, 6: begin
                n = $urandom_range(5);
                repeat (n) begin
                    case ($urandom_range(5))
                        0:       send_byte(CH_SEMI);
                        1:       send_byte(CH_NUL);
                        2:       send_byte(8'($urandom_range(CH_NINE, CH_ZERO)));
                        default: send_byte(param_noise());
                    endcase
                end
            end
            7: begin
                // text that can run past what the decoder keeps
                n = $urandom_range(20, 14);
                repeat (n)
                    send_byte($urandom_range(3) ? 8'($urandom_range(CH_NINE, CH_ZERO))
                                                : param_noise());
            end
            8: begin
                // stored nul hides the rest of the text
                if ($urandom_range(1))
                    send_number();
                send_byte(CH_NUL);
                send_byte(CH_SEMI);
                send_number();
            end
            default: ;
        endcase
    endtask

    task automatic send_final();
        case ($urandom_range(9))
            0: send_eoi();
            1, 2: send_byte(8'($urandom_range(CH_FIN_HI, CH_FIN_LO)));
            default: begin
                case ($urandom_range(8))
                    0:       send_byte(CH_UP);
                    1:       send_byte(CH_DOWN);
                    2:       send_byte(CH_RIGHT);
                    3:       send_byte(CH_LEFT);
                    4:       send_byte(CH_HOME);
                    5:       send_byte(CH_END);
                    default: send_byte(CH_TILDE);
                endcase
            end
        endcase
    endtask

    // one random unit of traffic, mostly well-formed sequences
    task automatic send_random_unit();
        logic [7:0] b;
        case ($urandom_range(99)) inside
            [0:54]: begin
                send_byte(CH_ESC);
                send_byte($urandom_range(1) ? CH_CSI : CH_SS3);
                send_params();
                send_final();
            end
            [55:66]: begin
                send_byte(CH_ESC);
                case ($urandom_range(5))
                    0:       send_byte(CH_WLEFT);
                    1:       send_byte(CH_WRIGHT);
                    2:       send_byte(CH_DEL);
                    3:       send_byte(CH_BS);
                    4:       send_eoi();
                    default: send_byte(8'($urandom_range(255)));
                endcase
            end
            [67:86]: begin
                b = 8'($urandom_range(255));
                send_byte((b == CH_ESC) ? 8'h9B : b);
            end
            [87:94]: send_eoi();
            default: send_byte(8'($urandom_range(255)));    // noise, escape included
        endcase
    endtask

    initial begin
        int target;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = 8'd0;
        s_axis_tlast   = 1'b0;
        hold_req       = 1'b0;
        items_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: byte extremes, end of input in idle and mid-sequence,
        // double escape, escape prefixes, arrows, word moves, paste start,
        // nul ending the kept text
        send_byte(8'h00);
        send_byte(8'hFF);
        send_eoi();
        send_byte(CH_ESC);
        send_byte(CH_ESC);
        send_byte(CH_ESC);
        send_byte(CH_DEL);
        send_byte(CH_ESC);
        send_text("[A");
        send_byte(CH_ESC);
        send_text("[1;5C");
        send_byte(CH_ESC);
        send_text("O200~");
        send_byte(CH_ESC);
        send_byte(CH_CSI);
        send_byte(CH_NUL);
        send_text(";D");
        send_byte(CH_ESC);
        send_byte(CH_CSI);
        send_eoi();

        // random traffic in four idling phases
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_req      <= 1'b1;
                end
                1: begin
                    send_idle_pct  = 47;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 47;
                end
                default: begin
                    send_idle_pct  = 22;
                    recv_stall_pct = 22;
                end
            endcase
            target = items_sent + RANDOM_ITEMS / 4;
            while (items_sent < target)
                send_random_unit();
        end
        s_axis_tvalid <= 1'b0;

        // drain the outstanding key results, then let the output settle
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
